// File: hdl/chpg_pkg.sv
// Shared constants for the cubic Hermite point generator.
package chpg_pkg;

  // Default sizes of the block.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_STEPS_DEF   = 64;

  // Width of the step count field and of the point counters.
  localparam int STEP_W = 7;

endpackage

// File: hdl/chpg_if.sv
// Valid/ready channel interfaces for segments in and points out.
interface chpg_seg_if #(
  parameter int CW = chpg_pkg::COORD_WIDTH_DEF
);
  import chpg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] start_tangent_x;
  logic signed [CW-1:0] start_tangent_y;
  logic signed [CW-1:0] end_tangent_x;
  logic signed [CW-1:0] end_tangent_y;
  logic [STEP_W-1:0]    step_count;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
    output start_tangent_x, start_tangent_y, end_tangent_x, end_tangent_y,
    output step_count,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
    input  start_tangent_x, start_tangent_y, end_tangent_x, end_tangent_y,
    input  step_count,
    output ready
  );
endinterface

interface chpg_pnt_if #(
  parameter int CW = chpg_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 last_point;

  modport source (
    output valid, point_x, point_y, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, last_point,
    output ready
  );
endinterface

// File: hdl/chpg_div.sv
// Restoring divider that forms floor(i * 2^FRAC_BITS / n) one quotient bit per cycle.
module chpg_div #(
  parameter int FRAC_BITS = chpg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chpg_pkg::STEP_W-1:0] dividend_i,
  input  logic [chpg_pkg::STEP_W-1:0] divisor_i,
  output logic [FRAC_BITS-1:0]        quot_o,
  output logic                        done_o
);
  import chpg_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [STEP_W-1:0]    rem_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [STEP_W:0]      rem2;
  logic [STEP_W:0]      diff;
  logic                 take;

  // One compare and subtract step; the dividend is below the divisor.
  always_comb begin
    rem2 = {rem_q, 1'b0};
    diff = rem2 - {1'b0, divisor_i};
    take = (rem2 >= {1'b0, divisor_i});
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(FRAC_BITS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= take ? diff[STEP_W-1:0] : rem2[STEP_W-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], take};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

// File: hdl/chpg_mul.sv
// Shared signed multiplier with a registered product.
module chpg_mul #(
  parameter int A_W = chpg_pkg::FRAC_BITS_DEF + 3,
  parameter int B_W = chpg_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);
  import chpg_pkg::*;

  // The product is taken every cycle; the sequencer decides which one it uses.
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// File: hdl/cubic_hermite_point_generator_top.sv
// Top level of the cubic Hermite point generator: sequencer and datapath registers.
//
// Usage: a segment (start and end points, start and end tangents, step count N)
// is transferred on seg_i. The block then produces N points on pnt_o for
// u = i/N, i = 0 .. N-1; the end point itself is not produced, and the final
// point carries last_point. A step count of zero is accepted and gives no
// point; a count above MAX_STEPS is treated as MAX_STEPS.
// seg_i is ready only while no segment is in work. The time per point is set
// by the bit-serial divider that forms u and by the single multiplier, which
// is used for u^2, u^3 and the eight weight-times-coordinate products in turn.
// Points leave through an output register, so the next point is computed
// while the receiver holds the current one; the sequencer only waits when a
// finished point meets a still-full output register.
// Reset (rst_ni low, asynchronous) drops any segment in work and empties the
// output register.
module cubic_hermite_point_generator_top #(
  parameter int MAX_STEPS   = chpg_pkg::MAX_STEPS_DEF,
  parameter int COORD_WIDTH = chpg_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = chpg_pkg::FRAC_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  chpg_seg_if.sink    seg_i,
  chpg_pnt_if.source  pnt_o
);
  import chpg_pkg::*;

  // Weight width, second multiplier operand, product and accumulator widths.
  localparam int WW  = FRAC_BITS + 3;
  localparam int MBW = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS + 1;
  localparam int PW  = WW + MBW;
  localparam int AW  = COORD_WIDTH + FRAC_BITS + 5;

  localparam logic signed [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
  localparam logic signed [AW-1:0] RND_BIAS =
    {{(AW - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [AW-1:0] ZERO_ACC = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_U2,
    ST_MUL_U3,
    ST_WGT,
    ST_MAC,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [STEP_W-1:0]             n_q;
  logic [STEP_W-1:0]             i_q;
  logic [3:0]                    k_q;
  logic                          out_valid_q;
  logic signed [COORD_WIDTH-1:0] out_x_q;
  logic signed [COORD_WIDTH-1:0] out_y_q;
  logic                          out_last_q;

  logic [FRAC_BITS-1:0]          u_q;
  logic [FRAC_BITS-1:0]          u2_q;
  logic signed [WW-1:0]          h_q [4];
  logic signed [WW-1:0]          h_d [4];
  logic signed [AW-1:0]          acc_q [2];
  logic signed [COORD_WIDTH-1:0] coord_q [8];

  logic                          seg_xfer;
  logic                          out_load;
  logic [STEP_W-1:0]             n_sat;
  logic                          is_last;
  logic                          div_done;
  logic [FRAC_BITS-1:0]          div_quot;
  logic signed [WW-1:0]          mul_a;
  logic signed [MBW-1:0]         mul_b;
  logic signed [PW-1:0]          p_q;
  logic [FRAC_BITS-1:0]          p_frac;
  logic signed [WW-1:0]          wa;
  logic signed [WW-1:0]          wb;
  logic signed [WW-1:0]          wc;
  logic signed [AW-1:0]          sh_x;
  logic signed [AW-1:0]          sh_y;
  logic signed [COORD_WIDTH-1:0] fin_x;
  logic signed [COORD_WIDTH-1:0] fin_y;

  assign seg_i.ready = (state_q == ST_IDLE);
  assign seg_xfer    = seg_i.valid && seg_i.ready;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || pnt_o.ready);
  assign n_sat       = (seg_i.step_count > STEP_W'(MAX_STEPS)) ?
                       STEP_W'(MAX_STEPS) : seg_i.step_count;
  assign is_last     = (i_q == n_q - STEP_W'(1));
  assign p_frac      = p_q[2*FRAC_BITS-1:FRAC_BITS];

  // Bit-serial division for u = floor(i * 2^FRAC_BITS / n).
  chpg_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIV_START),
    .dividend_i (i_q),
    .divisor_i  (n_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_MUL_U2: begin
        mul_a = WW'(u_q);
        mul_b = MBW'(u_q);
      end
      ST_MUL_U3: begin
        mul_a = WW'(p_frac);
        mul_b = MBW'(u_q);
      end
      default: begin
        mul_a = h_q[k_q[2:1]];
        mul_b = MBW'(coord_q[k_q[2:0]]);
      end
    endcase
  end

  chpg_mul #(
    .A_W (WW),
    .B_W (MBW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // Hermite weights from u, u^2 and u^3 (u^3 is in the product register).
  always_comb begin
    wa     = WW'(u_q);
    wb     = WW'(u2_q);
    wc     = WW'(p_frac);
    h_d[0] = (wc <<< 1) - (wb + (wb <<< 1)) + ONE_W;
    h_d[1] = (wb + (wb <<< 1)) - (wc <<< 1);
    h_d[2] = wc - (wb <<< 1) + wa;
    h_d[3] = wc - wb;
  end

  // Drop the fraction, rounding toward zero, and clamp to the coordinate range.
  always_comb begin
    sh_x = (acc_q[0] + (acc_q[0][AW-1] ? RND_BIAS : ZERO_ACC)) >>> FRAC_BITS;
    sh_y = (acc_q[1] + (acc_q[1][AW-1] ? RND_BIAS : ZERO_ACC)) >>> FRAC_BITS;
    if (sh_x > SAT_HI) begin
      fin_x = SAT_HI[COORD_WIDTH-1:0];
    end else if (sh_x < SAT_LO) begin
      fin_x = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      fin_x = sh_x[COORD_WIDTH-1:0];
    end
    if (sh_y > SAT_HI) begin
      fin_y = SAT_HI[COORD_WIDTH-1:0];
    end else if (sh_y < SAT_LO) begin
      fin_y = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      fin_y = sh_y[COORD_WIDTH-1:0];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // A finished point enters the output register, or a transfer empties it.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_x_q     <= fin_x;
        out_y_q     <= fin_y;
        out_last_q  <= is_last;
      end else if (pnt_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (seg_xfer && (seg_i.step_count != '0)) begin
            n_q     <= n_sat;
            i_q     <= '0;
            state_q <= ST_DIV_START;
          end
        end
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            state_q <= ST_MUL_U2;
          end
        end
        ST_MUL_U2: state_q <= ST_MUL_U3;
        ST_MUL_U3: state_q <= ST_WGT;
        ST_WGT: begin
          k_q     <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (k_q == 4'd8) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + STEP_W'(1);
              state_q <= ST_DIV_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: segment operands, powers of u, weights, sums.
  always_ff @(posedge clk_i) begin
    if (seg_xfer) begin
      coord_q[0] <= seg_i.start_x;
      coord_q[1] <= seg_i.start_y;
      coord_q[2] <= seg_i.end_x;
      coord_q[3] <= seg_i.end_y;
      coord_q[4] <= seg_i.start_tangent_x;
      coord_q[5] <= seg_i.start_tangent_y;
      coord_q[6] <= seg_i.end_tangent_x;
      coord_q[7] <= seg_i.end_tangent_y;
    end
    case (state_q)
      ST_DIV_WAIT: begin
        if (div_done) begin
          u_q <= div_quot;
        end
      end
      ST_MUL_U3: u2_q <= p_frac;
      ST_WGT: begin
        h_q[0] <= h_d[0];
        h_q[1] <= h_d[1];
        h_q[2] <= h_d[2];
        h_q[3] <= h_d[3];
      end
      ST_MAC: begin
        // Products arrive in the cycle after issue; even ones are x, odd ones y.
        if (k_q == 4'd0) begin
          acc_q[0] <= '0;
          acc_q[1] <= '0;
        end else begin
          acc_q[~k_q[0]] <= acc_q[~k_q[0]] + AW'(p_q);
        end
      end
      default: ;
    endcase
  end

  assign pnt_o.valid      = out_valid_q;
  assign pnt_o.point_x    = out_x_q;
  assign pnt_o.point_y    = out_y_q;
  assign pnt_o.last_point = out_last_q;

endmodule
